[rtl/spq_pkg.sv]
// shared types and constants of the stable priority queue
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int PRI_W  = 3;
	localparam int OCC_W  = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_REMOVED  = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADPRI   = 3'd4
	} status_t;

endpackage

[rtl/spq_if.sv]
// request and response channel interfaces of the stable priority queue
interface spq_req_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic signed [spq_pkg::DATA_W-1:0] data_value;
	logic [spq_pkg::PRI_W-1:0]         priority_req;

	modport source (output valid, output operation, output data_value,
		output priority_req, input ready);
	modport sink (input valid, input operation, input data_value,
		input priority_req, output ready);
endinterface

interface spq_rsp_if;
	logic                              valid;
	logic                              ready;
	spq_pkg::status_t                  status;
	logic signed [spq_pkg::DATA_W-1:0] removed_value;
	logic [spq_pkg::OCC_W-1:0]         occupancy;

	modport source (output valid, output status, output removed_value,
		output occupancy, input ready);
	modport sink (input valid, input status, input removed_value,
		input occupancy, output ready);
endinterface

[rtl/spq_ram.sv]
// generic simple dual-port ram with registered read
module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/stable_priority_queue_core.sv]
// top level of the stable priority queue: per-level fifos in one ram
//
// usage: requests arrive on the req channel (operation, data_value,
// priority_req) and every request gives exactly one response on the rsp
// channel (status, removed_value, occupancy). an insert puts its word behind
// all stored words of equal or higher priority; a remove returns the oldest
// word of the highest priority. bad priority is checked before full.
// storage: one ram holds a circular fifo per priority level; head, tail and
// count of each level live in flops, so finding the top level is a small
// priority encoder over the per-level non-empty flags.
// timing: a transfer enters the work state and registers the ram read of
// the single read port, whose data is only available the cycle after the
// transfer; no new request is taken until the response enters the output
// register, but one is taken while that response still waits on rsp.
// reset: all levels empty, stored count zero; the ram is not cleared, since
// only written slots are ever read.
// stall: while rsp.ready is low the response holds in the output register;
// one more request may be taken and is parked until the output frees up.
module stable_priority_queue_core #(
	parameter int CAPACITY     = 16,
	parameter int TOP_PRIORITY = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	spq_req_if.sink     req,
	spq_rsp_if.source   rsp
);

	localparam int NLEV  = TOP_PRIORITY + 1;
	localparam int LVW   = $clog2(NLEV);
	localparam int IW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int AW    = LVW + IW;
	localparam int DEPTH = NLEV * (2 ** IW);

	typedef enum logic {
		S_IDLE,
		S_WORK
	} state_t;

	state_t state_q;

	// per-level fifo bookkeeping
	logic [IW-1:0] head_q [NLEV];
	logic [IW-1:0] tail_q [NLEV];
	logic [CW-1:0] lcnt_q [NLEV];
	logic [CW-1:0] count_q;

	// item held between transfer and response
	spq_pkg::status_t status_s1;
	logic             taken_s1;

	// output register
	logic                              out_valid_q;
	spq_pkg::status_t                  status_q;
	logic signed [spq_pkg::DATA_W-1:0] value_q;
	logic [spq_pkg::OCC_W-1:0]         occ_q;

	logic                       accept;
	logic                       is_insert;
	logic                       bad_pri;
	logic                       full;
	logic                       empty;
	logic                       insert_ok;
	logic                       remove_ok;
	logic [LVW-1:0]             top_lvl;
	logic [LVW-1:0]             sel_lvl;
	logic [IW-1:0]              sel_head;
	logic [IW-1:0]              sel_tail;
	logic [CW-1:0]              sel_cnt;
	logic [IW-1:0]              head_nxt;
	logic [IW-1:0]              tail_nxt;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              raddr;
	logic [spq_pkg::DATA_W-1:0] rdata;
	logic                       load_out;
	spq_pkg::status_t           status_d;

	assign accept    = req.valid && req.ready;
	assign is_insert = (req.operation == spq_pkg::OP_INSERT);
	assign bad_pri   = 32'(req.priority_req) > TOP_PRIORITY;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign insert_ok = accept && is_insert && !bad_pri && !full;
	assign remove_ok = accept && !is_insert && !empty;

	// highest level holding a word
	always_comb begin
		top_lvl = '0;
		for (int l = 0; l < NLEV; l++) begin
			if (lcnt_q[l] != '0) begin
				top_lvl = LVW'(l);
			end
		end
	end

	assign sel_lvl  = is_insert ? LVW'(req.priority_req) : top_lvl;
	assign sel_head = head_q[sel_lvl];
	assign sel_tail = tail_q[sel_lvl];
	assign sel_cnt  = lcnt_q[sel_lvl];

	// circular index advance, wraps at capacity
	assign head_nxt = (sel_head == IW'(CAPACITY - 1)) ? '0 : sel_head + IW'(1);
	assign tail_nxt = (sel_tail == IW'(CAPACITY - 1)) ? '0 : sel_tail + IW'(1);

	assign waddr = {sel_lvl, sel_tail};
	assign raddr = {sel_lvl, sel_head};

	always_comb begin
		if (is_insert) begin
			if (bad_pri) begin
				status_d = spq_pkg::ST_BADPRI;
			end else if (full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				status_d = spq_pkg::ST_INSERTED;
			end
		end else begin
			status_d = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_REMOVED;
		end
	end

	spq_ram #(
		.WIDTH (spq_pkg::DATA_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (insert_ok),
		.waddr (waddr),
		.wdata (req.data_value),
		.re    (remove_ok),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign load_out = (state_q == S_WORK) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_s1   <= spq_pkg::ST_INSERTED;
			taken_s1    <= 1'b0;
			status_q    <= spq_pkg::ST_INSERTED;
			value_q     <= '0;
			occ_q       <= '0;
			for (int l = 0; l < NLEV; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				lcnt_q[l] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_s1 <= status_d;
						taken_s1  <= remove_ok;
						state_q   <= S_WORK;
					end
					if (insert_ok) begin
						tail_q[sel_lvl] <= tail_nxt;
						lcnt_q[sel_lvl] <= sel_cnt + CW'(1);
						count_q         <= count_q + CW'(1);
					end
					if (remove_ok) begin
						head_q[sel_lvl] <= head_nxt;
						lcnt_q[sel_lvl] <= sel_cnt - CW'(1);
						count_q         <= count_q - CW'(1);
					end
				end
				S_WORK: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// output register, ram data is valid in the work state
			if (load_out) begin
				out_valid_q <= 1'b1;
				status_q    <= status_s1;
				value_q     <= taken_s1 ? rdata : '0;
				occ_q       <= spq_pkg::OCC_W'(count_q);
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_value = value_q;
	assign rsp.occupancy     = occ_q;

	// stored count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("stored count above capacity");

	// a transfer always moves the block into the work state
	a_accept_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_WORK))
		else $error("transfer did not start work");

	// only a successful remove returns a nonzero word
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != spq_pkg::ST_REMOVED)) |-> (rsp.removed_value == '0))
		else $error("nonzero value on a response that removed nothing");

	// an insert that was taken raises the stored count by one
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		insert_ok |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not raise stored count");

endmodule

[test/testbench.sv]
// self-checking testbench of the stable priority queue core
module testbench;

	localparam int CAP        = 16;
	localparam int TOP_PRI    = 5;
	// cycles with no transfer on either channel before the run is given up
	localparam int IDLE_LIMIT = 5000;
	// slack left at the end, after every owed response has arrived
	localparam int DRAIN_WAIT = 8;

	typedef struct {
		logic signed [spq_pkg::DATA_W-1:0] word;
		logic [spq_pkg::PRI_W-1:0]         level;
	} slot_t;

	typedef struct {
		spq_pkg::status_t                  status;
		logic signed [spq_pkg::DATA_W-1:0] value;
		logic [spq_pkg::OCC_W-1:0]         occ;
	} rsp_t;

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	stable_priority_queue_core #(
		.CAPACITY     (CAP),
		.TOP_PRIORITY (TOP_PRI)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// software copy of the stored words, slot 0 is the next one served
	slot_t held_words[$];
	// responses still owed by the block, oldest first
	rsp_t  awaited_rsp[$];

	int mismatches  = 0;
	int accepted    = 0;
	int peak_occ    = 0;
	int idle_cycles = 0;
	int status_seen[5] = '{default: 0};

	// sender pacing: bursts of back-to-back transfers separated by random gaps
	int burst_left = 0;
	int max_burst  = 1;
	int max_gap    = 0;
	// receiver pacing: runs of ready high followed by stalls, 0 stall means always ready
	int rx_max_run   = 1;
	int rx_max_stall = 0;
	int run_left     = 0;
	int stall_left   = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// apply one request to the software queue and return the response it owes
	function automatic rsp_t queue_apply(spq_pkg::op_t op,
			logic signed [spq_pkg::DATA_W-1:0] word, logic [spq_pkg::PRI_W-1:0] pri);
		rsp_t  r;
		slot_t s;
		int    pos;
		r.value = '0;
		if (op == spq_pkg::OP_INSERT) begin
			// priority is checked before fullness
			if (pri > TOP_PRI) begin
				r.status = spq_pkg::ST_BADPRI;
			end else if (held_words.size() >= CAP) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				// the new word lands behind every word of equal or higher priority
				pos = 0;
				while (pos < held_words.size() && held_words[pos].level >= pri)
					pos++;
				s.word  = word;
				s.level = pri;
				held_words.insert(pos, s);
				r.status = spq_pkg::ST_INSERTED;
			end
		end else begin
			if (held_words.size() == 0) begin
				r.status = spq_pkg::ST_EMPTY;
			end else begin
				r.value = held_words[0].word;
				held_words.pop_front();
				r.status = spq_pkg::ST_REMOVED;
			end
		end
		r.occ = spq_pkg::OCC_W'(held_words.size());
		return r;
	endfunction

	function automatic logic signed [spq_pkg::DATA_W-1:0] rand_word();
		// one word in eight is a corner value: a signed extreme, zero or minus one
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh0000_0000;
				default: return -32'sd1;
			endcase
		end
		return spq_pkg::DATA_W'($urandom);
	endfunction

	function automatic logic [spq_pkg::PRI_W-1:0] rand_pri(int bad_pct);
		if (int'($urandom_range(99)) < bad_pct)
			return spq_pkg::PRI_W'($urandom_range(TOP_PRI + 1, 7));
		return spq_pkg::PRI_W'($urandom_range(0, TOP_PRI));
	endfunction

	task automatic set_pace(int burst, int gap, int run, int stall);
		max_burst    = burst;
		max_gap      = gap;
		rx_max_run   = run;
		rx_max_stall = stall;
		burst_left   = 0;
	endtask

	// drive one request from a falling edge and hold it until the transfer
	task automatic send_req(spq_pkg::op_t op, logic signed [spq_pkg::DATA_W-1:0] word,
			logic [spq_pkg::PRI_W-1:0] pri);
		int gap;
		if (burst_left == 0) begin
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			burst_left = $urandom_range(1, max_burst);
			repeat (gap) begin
				req_ch.valid = 1'b0;
				@(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid        = 1'b1;
		req_ch.operation    = op;
		req_ch.data_value   = word;
		req_ch.priority_req = pri;
		do @(posedge clk); while (!req_ch.ready);
		// transfer happened at this edge, so the model moves now
		awaited_rsp.push_back(queue_apply(op, word, pri));
		accepted++;
		@(negedge clk);
	endtask

	task automatic run_random(int count, int insert_pct, int bad_pct);
		repeat (count) begin
			if (int'($urandom_range(99)) < insert_pct)
				send_req(spq_pkg::OP_INSERT, rand_word(), rand_pri(bad_pct));
			else
				send_req(spq_pkg::OP_REMOVE, rand_word(), spq_pkg::PRI_W'($urandom));
		end
	endtask

	task automatic test_empty_and_bad_priority();
		set_pace(1, 0, 1, 0);
		send_req(spq_pkg::OP_REMOVE, 32'sh1234_5678, 3'd0);
		send_req(spq_pkg::OP_INSERT, 32'sh7fff_ffff, 3'd6);
		send_req(spq_pkg::OP_INSERT, 32'sh8000_0000, 3'd7);
	endtask

	task automatic test_priority_order();
		set_pace(3, 2, 2, 2);
		// two words on levels 0, 2 and 5 and one on level 3 to show fifo order within a level
		send_req(spq_pkg::OP_INSERT, 32'sh8000_0000, 3'd0);
		send_req(spq_pkg::OP_INSERT, 32'sh7fff_ffff, 3'd5);
		send_req(spq_pkg::OP_INSERT, 32'sh0000_0000, 3'd2);
		send_req(spq_pkg::OP_INSERT, -32'sd1, 3'd5);
		send_req(spq_pkg::OP_INSERT, 32'sh0000_0001, 3'd0);
		send_req(spq_pkg::OP_INSERT, 32'sh5a5a_5a5a, 3'd2);
		send_req(spq_pkg::OP_INSERT, 32'sha5a5_a5a5, 3'd3);
		repeat (7)
			send_req(spq_pkg::OP_REMOVE, -32'sd1, 3'd7);
		send_req(spq_pkg::OP_REMOVE, 32'sh0, 3'd0);
	endtask

	// fill to capacity, poke the full queue, then drain past empty
	task automatic test_fill_and_drain(int rounds);
		repeat (rounds) begin
			set_pace($urandom_range(1, 6), $urandom_range(0, 4),
				$urandom_range(1, 6), $urandom_range(0, 4));
			while (held_words.size() < CAP)
				send_req(spq_pkg::OP_INSERT, rand_word(), rand_pri(10));
			send_req(spq_pkg::OP_INSERT, rand_word(), rand_pri(0));
			// bad priority wins over a full queue
			send_req(spq_pkg::OP_INSERT, rand_word(),
				spq_pkg::PRI_W'($urandom_range(TOP_PRI + 1, 7)));
			while (held_words.size() > 0)
				send_req(spq_pkg::OP_REMOVE, rand_word(), spq_pkg::PRI_W'($urandom));
			send_req(spq_pkg::OP_REMOVE, rand_word(), spq_pkg::PRI_W'($urandom));
		end
	endtask

	task automatic test_back_to_back();
		set_pace(1, 0, 1, 0);
		run_random(150, 55, 5);
	endtask

	task automatic test_long_stalls();
		set_pace(8, 3, 3, 20);
		run_random(150, 60, 5);
	endtask

	task automatic test_random_mix();
		int seg;
		for (seg = 0; seg < 14; seg++) begin
			// every fourth segment runs with no idling at all
			if (seg % 4 == 3)
				set_pace(1, 0, 1, 0);
			else
				set_pace($urandom_range(1, 10), $urandom_range(0, 6),
					$urandom_range(1, 8), $urandom_range(0, 8));
			// lean toward filling, then toward draining, then balanced
			case (seg % 3)
				0: run_random(50, 75, 8);
				1: run_random(50, 25, 8);
				default: run_random(50, 50, 8);
			endcase
		end
	endtask

	// receiver: ready follows its own run and stall pattern
	always @(negedge clk) begin
		if (rx_max_stall == 0) begin
			rsp_ch.ready = 1'b1;
		end else begin
			if (run_left == 0 && stall_left == 0) begin
				run_left   = $urandom_range(1, rx_max_run);
				stall_left = $urandom_range(1, rx_max_stall);
			end
			if (run_left != 0) begin
				rsp_ch.ready = 1'b1;
				run_left--;
			end else begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end
		end
	end

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// response checker: every response transfer is matched to the oldest expectation
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected response status %0d value %0d occ %0d",
					rsp_ch.status, rsp_ch.removed_value, rsp_ch.occupancy));
			end else begin
				exp_r = awaited_rsp.pop_front();
				if (rsp_ch.status !== exp_r.status ||
						rsp_ch.removed_value !== exp_r.value ||
						rsp_ch.occupancy !== exp_r.occ)
					report_mismatch($sformatf({"expected status %0d value %0d occ %0d, ",
						"got status %0d value %0d occ %0d"},
						exp_r.status, exp_r.value, exp_r.occ,
						rsp_ch.status, rsp_ch.removed_value, rsp_ch.occupancy));
				if (exp_r.status <= spq_pkg::ST_BADPRI)
					status_seen[exp_r.status]++;
				if (int'(exp_r.occ) > peak_occ)
					peak_occ = exp_r.occ;
			end
		end
	end

	// watchdog: counts edges at which neither channel has a transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d responses owed",
					IDLE_LIMIT, awaited_rsp.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		// every block input known from time zero
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.operation    = spq_pkg::OP_INSERT;
		req_ch.data_value   = '0;
		req_ch.priority_req = '0;
		rsp_ch.ready        = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_and_bad_priority();
		test_priority_order();
		test_fill_and_drain(3);
		test_back_to_back();
		test_long_stalls();
		test_random_mix();

		req_ch.valid = 1'b0;
		// the watchdog bounds this wait if responses stop coming
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (awaited_rsp.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", awaited_rsp.size()));

		$display({"covered %0d requests: %0d inserted, %0d removed, %0d empty, ",
			"%0d full, %0d bad priority"},
			accepted, status_seen[spq_pkg::ST_INSERTED], status_seen[spq_pkg::ST_REMOVED],
			status_seen[spq_pkg::ST_EMPTY], status_seen[spq_pkg::ST_FULL],
			status_seen[spq_pkg::ST_BADPRI]);
		$display("peak occupancy %0d of %0d, %0d mismatches", peak_occ, CAP, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
